[rtl/uje_pkg.sv]
// Shared types, constants and helpers of the URL / JSON escape encoder.
// No dependencies; used by every module under rtl.
package uje_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int TOTAL_W     = 16;
  localparam int CMP_W       = (LENGTH_BITS + 1 > 17) ? LENGTH_BITS + 1 : 17;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic REG_ESCAPE_MODE     = 1'b0;
  localparam logic REG_BUFFER_CAPACITY = 1'b1;

  localparam logic MODE_URL  = 1'b0;
  localparam logic MODE_JSON = 1'b1;

  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PERCENT,
    KIND_BACKSLASH,
    KIND_END
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data;
    logic                 wr;
    logic [TOTAL_W-1:0]   total;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic pop;
  } pop_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else             c = 8'h41 + {4'd0, nib} - 8'd10;
    return c;
  endfunction

endpackage

[rtl/uje_front.sv]
// Front end: accepts source bytes, classifies them, runs the length counter and fit test.
// Depends on uje_pkg; feeds uje_queue.
module uje_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         escape_mode,
  input  logic [15:0]                  buffer_capacity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  logic                         queue_full,
  output uje_pkg::push_t               push
);

  logic [uje_pkg::LENGTH_BITS-1:0] output_length;
  logic [uje_pkg::LENGTH_BITS-1:0] output_length_next;
  logic [1:0]                      k;
  logic [uje_pkg::CMP_W-1:0]       need;
  logic                            fit;
  logic                            accept;
  uje_pkg::kind_t                  kind;

  function automatic logic url_plain(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || c == uje_pkg::CH_DASH ||
           c == uje_pkg::CH_DOT || c == uje_pkg::CH_UNDER || c == uje_pkg::CH_TILDE;
  endfunction

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_byte == 8'd0) begin
      kind = uje_pkg::KIND_END;
      k    = 2'd1;
    end else if (escape_mode == uje_pkg::MODE_URL) begin
      if (url_plain(in_byte)) begin
        kind = uje_pkg::KIND_PLAIN;
        k    = 2'd1;
      end else begin
        kind = uje_pkg::KIND_PERCENT;
        k    = 2'd3;
      end
    end else if (in_byte == uje_pkg::CH_QUOTE || in_byte == uje_pkg::CH_LBRACE ||
                 in_byte == uje_pkg::CH_RBRACE) begin
      kind = uje_pkg::KIND_BACKSLASH;
      k    = 2'd2;
    end else begin
      kind = uje_pkg::KIND_PLAIN;
      k    = 2'd1;
    end

    need = uje_pkg::CMP_W'(output_length) + uje_pkg::CMP_W'(k);
    fit  = (buffer_capacity != 16'd0) &&
           (need <= uje_pkg::CMP_W'(buffer_capacity)) &&
           (need <= uje_pkg::CMP_W'(uje_pkg::LEN_MAX));

    if (kind == uje_pkg::KIND_END) begin
      output_length_next = '0;
    end else if (need > uje_pkg::CMP_W'(uje_pkg::LEN_MAX)) begin
      output_length_next = uje_pkg::LEN_MAX;
    end else begin
      output_length_next = uje_pkg::LENGTH_BITS'(need);
    end

    push.push      = accept;
    push.cmd.kind  = kind;
    push.cmd.data  = in_byte;
    push.cmd.wr    = fit;
    push.cmd.total = (kind == uje_pkg::KIND_END) ?
                     uje_pkg::TOTAL_W'(output_length) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (accept) begin
      output_length <= output_length_next;
    end
  end

endmodule

[rtl/uje_queue.sv]
// Short command queue between the front and back ends.
// Depends on uje_pkg.
module uje_queue (
  input  logic           clk,
  input  logic           rst,
  input  uje_pkg::push_t push,
  output logic           full,
  input  uje_pkg::pop_t  pop,
  output logic           head_valid,
  output uje_pkg::cmd_t  head
);

  uje_pkg::cmd_t                mem [uje_pkg::QUEUE_DEPTH];
  logic [uje_pkg::QPTR_W-1:0]   wptr;
  logic [uje_pkg::QPTR_W-1:0]   rptr;
  logic [uje_pkg::QPTR_W:0]     count;
  logic                         do_push;
  logic                         do_pop;

  assign full       = (count == (uje_pkg::QPTR_W+1)'(uje_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  assign do_push    = push.push && !full;
  assign do_pop     = pop.pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/uje_back.sv]
// Back end: expands queued commands into registered output beats, one per cycle unless stalled.
// Depends on uje_pkg; reads uje_queue.
module uje_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  uje_pkg::cmd_t                 head,
  output uje_pkg::pop_t                 pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          is_end,
  output logic                          written,
  output logic [uje_pkg::TOTAL_W-1:0]   total_length,
  output logic                          last_of_run
);

  logic [1:0]  idx;
  logic        advance;
  logic        beat_last;
  logic [7:0]  beat_byte;

  always_comb begin
    beat_last = 1'b1;
    beat_byte = head.data;
    case (head.kind)
      uje_pkg::KIND_PLAIN: begin
        beat_byte = head.data;
        beat_last = 1'b1;
      end
      uje_pkg::KIND_PERCENT: begin
        case (idx)
          2'd0: begin
            beat_byte = uje_pkg::CH_PERCENT;
            beat_last = 1'b0;
          end
          2'd1: begin
            beat_byte = uje_pkg::hex_char(head.data[7:4] & uje_pkg::NIBBLE_MASK);
            beat_last = 1'b0;
          end
          default: begin
            beat_byte = uje_pkg::hex_char(head.data[3:0] & uje_pkg::NIBBLE_MASK);
            beat_last = 1'b1;
          end
        endcase
      end
      uje_pkg::KIND_BACKSLASH: begin
        beat_byte = (idx == 2'd0) ? uje_pkg::CH_BACKSLASH : head.data;
        beat_last = (idx != 2'd0);
      end
      uje_pkg::KIND_END: begin
        beat_byte = 8'd0;
        beat_last = 1'b1;
      end
      default: begin
        beat_byte = head.data;
        beat_last = 1'b1;
      end
    endcase
  end

  assign advance = head_valid && (!out_valid || out_ready);
  assign pop.pop = advance && beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (!out_valid || out_ready) out_valid <= head_valid;
      if (advance) idx <= beat_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte     <= beat_byte;
      is_end       <= (head.kind == uje_pkg::KIND_END);
      written      <= head.wr;
      total_length <= head.total;
      last_of_run  <= beat_last;
    end
  end

endmodule

[rtl/url_json_escape_encoder.sv]
// Top level of the URL / JSON escape encoder: configuration registers and wiring.
// Depends on uje_pkg, uje_front, uje_queue and uje_back.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | s_axis_tvalid/tready   | tdata[7:0] in_byte
//  m_axis   | out       | m_axis_tvalid/tready   | tdata out_byte,total_length; tuser; tlast
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Output runs at one beat per cycle while m_axis_tready is high; a plain byte takes 1 beat,
// a JSON escape 2, a percent escape 3, so the back end sets the sustained input rate.
// The front end takes one byte per cycle while the four-entry queue has room.
// An accepted byte is written into the queue, then registered out of its head as a beat.
// Reset clears the length counter, the queue and both registers; no clearing pass.
module url_json_escape_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] total_length
  output logic [1:0]  m_axis_tuser,   // [0] is_end, [1] written
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic           escape_mode;
  logic [15:0]    buffer_capacity;
  logic           queue_full;
  logic           head_valid;
  uje_pkg::cmd_t  head;
  uje_pkg::push_t push;
  uje_pkg::pop_t  pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode     <= uje_pkg::MODE_URL;
      buffer_capacity <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uje_pkg::REG_ESCAPE_MODE:     escape_mode     <= cfg_data[0];
        uje_pkg::REG_BUFFER_CAPACITY: buffer_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  uje_front u_front (
    .clk             (clk),
    .rst             (rst),
    .escape_mode     (escape_mode),
    .buffer_capacity (buffer_capacity),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_byte         (s_axis_tdata),
    .queue_full      (queue_full),
    .push            (push)
  );

  uje_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  uje_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (m_axis_tdata[7:0]),
    .is_end       (m_axis_tuser[0]),
    .written      (m_axis_tuser[1]),
    .total_length (m_axis_tdata[23:8]),
    .last_of_run  (m_axis_tlast)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("end beat without last_of_run");

  a_total_only_on_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:8] == 16'd0)
    else $error("total_length set on a data beat");

  a_run_written_steady: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser[1] == $past(m_axis_tuser[1]))
    else $error("expansion broken or written flag changed mid-run");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push.push)
    else $error("push into full queue");

endmodule

[dv/url_json_escape_encoder_checker.sv]
// Scoreboard for the URL / JSON escape encoder: follows register writes and input bytes,
// predicts each encoded output beat and compares the beats that the block hands out.
// Depends on uje_pkg for widths, register indexes, modes and character codes.
module url_json_escape_encoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]                  data;
    logic                        is_end;
    logic                        written;
    logic [uje_pkg::TOTAL_W-1:0] total;
    logic                        last;
  } enc_beat_t;

  localparam logic [127:0] HEX_ASCII = "FEDCBA9876543210";

  enc_beat_t                       expected_beats[$];
  logic [uje_pkg::LENGTH_BITS-1:0] enc_length;
  logic                            escape_sel;
  logic [15:0]                     capacity;

  function automatic logic fits_whole(input int unsigned k);
    logic [uje_pkg::LENGTH_BITS:0] need;
    logic [uje_pkg::LENGTH_BITS:0] kk;
    kk = (uje_pkg::LENGTH_BITS+1)'(k);
    need = {1'b0, enc_length} + kk;
    return capacity != 16'd0 && need <= {1'b0, capacity} &&
           need <= {1'b0, uje_pkg::LEN_MAX};
  endfunction

  function automatic logic [uje_pkg::LENGTH_BITS-1:0] advanced(input int unsigned k);
    logic [uje_pkg::LENGTH_BITS:0] need;
    logic [uje_pkg::LENGTH_BITS:0] kk;
    kk = (uje_pkg::LENGTH_BITS+1)'(k);
    need = {1'b0, enc_length} + kk;
    return (need > {1'b0, uje_pkg::LEN_MAX}) ? uje_pkg::LEN_MAX
                                             : need[uje_pkg::LENGTH_BITS-1:0];
  endfunction

  function automatic logic url_unreserved(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == uje_pkg::CH_DASH || c == uje_pkg::CH_DOT || c == uje_pkg::CH_UNDER ||
           c == uje_pkg::CH_TILDE;
  endfunction

  task automatic push_beat(input logic [7:0] data, input logic is_end, input logic written,
                           input logic [uje_pkg::TOTAL_W-1:0] total, input logic last);
    enc_beat_t b;
    b.data    = data;
    b.is_end  = is_end;
    b.written = written;
    b.total   = total;
    b.last    = last;
    expected_beats.push_back(b);
  endtask

  task automatic predict_encoding(input logic [7:0] c);
    logic wr;
    if (c == 8'h00) begin
      push_beat(8'h00, 1'b1, fits_whole(1), enc_length[uje_pkg::TOTAL_W-1:0], 1'b1);
      enc_length = '0;
    end else if (escape_sel == uje_pkg::MODE_URL) begin
      if (url_unreserved(c)) begin
        push_beat(c, 1'b0, fits_whole(1), '0, 1'b1);
        enc_length = advanced(1);
      end else begin
        wr = fits_whole(3);
        push_beat(uje_pkg::CH_PERCENT, 1'b0, wr, '0, 1'b0);
        push_beat(HEX_ASCII[{c[7:4], 3'b000} +: 8], 1'b0, wr, '0, 1'b0);
        push_beat(HEX_ASCII[{c[3:0], 3'b000} +: 8], 1'b0, wr, '0, 1'b1);
        enc_length = advanced(3);
      end
    end else if (c == uje_pkg::CH_QUOTE || c == uje_pkg::CH_LBRACE ||
                 c == uje_pkg::CH_RBRACE) begin
      wr = fits_whole(2);
      push_beat(uje_pkg::CH_BACKSLASH, 1'b0, wr, '0, 1'b0);
      push_beat(c, 1'b0, wr, '0, 1'b1);
      enc_length = advanced(2);
    end else begin
      push_beat(c, 1'b0, fits_whole(1), '0, 1'b1);
      enc_length = advanced(1);
    end
  endtask

  task automatic flag_mismatch(input string why, input enc_beat_t want, input enc_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch, %s: expected byte %02h end %0b wr %0b len %0d last %0b,",
               $realtime, why, want.data, want.is_end, want.written, want.total, want.last);
      $display("    got byte %02h end %0b wr %0b len %0d last %0b",
               got.data, got.is_end, got.written, got.total, got.last);
    end
  endtask

  always @(posedge clk) begin
    enc_beat_t got;
    enc_beat_t want;
    if (rst) begin
      expected_beats.delete();
      enc_length = '0;
      escape_sel = uje_pkg::MODE_URL;
      capacity   = 16'd0;
      mismatches = 0;
      beats_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == uje_pkg::REG_ESCAPE_MODE) escape_sel = cfg_data[0];
        else capacity = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.data    = m_axis_tdata[7:0];
        got.total   = m_axis_tdata[23:8];
        got.is_end  = m_axis_tuser[0];
        got.written = m_axis_tuser[1];
        got.last    = m_axis_tlast;
        beats_seen++;
        if (expected_beats.size() == 0) begin
          flag_mismatch("beat with nothing expected", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) flag_mismatch("field differs", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_encoding(s_axis_tdata);
    end
    pending = expected_beats.size();
  end

endmodule

[dv/url_json_escape_encoder_test.sv]
// Top of the escape encoder regression: clock, reset, stream and register stimulus, verdict.
// Depends on uje_pkg, the url_json_escape_encoder RTL and url_json_escape_encoder_checker.
module url_json_escape_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 420;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int pending;
  int beats_seen;
  int items_sent    = 0;
  int strings_sent  = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int stall_cycles  = 0;
  int rx_cycle      = 0;
  logic [1:0] rx_style = 2'd0;

  url_json_escape_encoder i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  url_json_escape_encoder_checker i_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending, .beats_seen
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_style <= 2'($urandom_range(0, 3));
    case (rx_style)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= rx_cycle[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("url_json_escape_encoder regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (c == 8'h00) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] random_char();
    logic [8*13-1:0] plain_set;
    plain_set = "azAZ09-._~qK7";
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return plain_set[8 * $urandom_range(0, 12) +: 8];
      4: return ($urandom_range(0, 1) != 0) ? uje_pkg::CH_QUOTE : uje_pkg::CH_PERCENT;
      5: return ($urandom_range(0, 1) != 0) ? uje_pkg::CH_LBRACE : uje_pkg::CH_RBRACE;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_string(input int len, input bit terminate);
    repeat (len) send_char(random_char());
    if (terminate) send_char(8'h00);
  endtask

  // hold off until every expected beat has come back and the pipeline is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [15:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= uje_pkg::REG_ESCAPE_MODE;
    cfg_data  <= {15'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= uje_pkg::REG_BUFFER_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int         random_goal;
    logic       mode;
    logic [15:0] cap;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = uje_pkg::REG_ESCAPE_MODE;
    cfg_data      = 16'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_config(uje_pkg::MODE_URL, 16'hFFFF);
    send_text("aZ09-._~@[`{");
    send_char(8'hFF);
    send_char(8'h00);
    set_config(uje_pkg::MODE_JSON, 16'd4);
    send_text("\"{}x");
    send_char(8'h00);
    send_char(8'h00);
    set_config(uje_pkg::MODE_URL, 16'd0);
    send_text(" a");
    send_char(8'h00);
    set_config(uje_pkg::MODE_URL, 16'd1);
    send_char(8'h00);
    send_char("b");
    send_char(8'h00);

    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: cap = 16'd0;
        1: cap = 16'($urandom_range(1, 8));
        2: cap = 16'($urandom_range(9, 40));
        3: cap = 16'hFFFF;
        default: cap = 16'($urandom());
      endcase
      set_config(mode, cap);
      repeat ($urandom_range(1, 6)) send_string($urandom_range(0, 12), 1'b1);
      if ($urandom_range(0, 3) == 0) send_string($urandom_range(1, 5), 1'b0);
    end
    send_char(8'h00);
    drain();

    $display("covered %0d input bytes in %0d strings under %0d register settings",
             items_sent, strings_sent, settings_used);
    $display("checked %0d output beats across both modes, full, tiny and zero capacities",
             beats_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("url_json_escape_encoder regression: pass");
    end else begin
      $display("%0d mismatches, %0d beats still expected", mismatches, pending);
      $display("url_json_escape_encoder regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/uje_pkg.sv
rtl/uje_front.sv
rtl/uje_queue.sv
rtl/uje_back.sv
rtl/url_json_escape_encoder.sv
dv/url_json_escape_encoder_checker.sv
dv/url_json_escape_encoder_test.sv
